// ===== rtl/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

  typedef enum logic [3:0] {
    TK_LPAREN  = 4'd0,
    TK_RPAREN  = 4'd1,
    TK_LBRACE  = 4'd2,
    TK_RBRACE  = 4'd3,
    TK_COLON   = 4'd4,
    TK_COMMA   = 4'd5,
    TK_ARROW   = 4'd6,
    TK_STRING  = 4'd7,
    TK_NUMBER  = 4'd8,
    TK_KEYWORD = 4'd9,
    TK_BOOLEAN = 4'd10,
    TK_TYPE    = 4'd11,
    TK_IDENT   = 4'd12,
    TK_END     = 4'd13,
    TK_ERROR   = 4'd14
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  localparam int MAX_TOKENS = 3;

  typedef token_t [MAX_TOKENS-1:0] token_set_t;

endpackage

`default_nettype wire

// ===== rtl/stt_word_match.sv =====
`default_nettype none

module stt_word_match (
  input  wire logic [2:0]          chars_seen,
  input  wire logic [7:0]          candidates,
  input  wire logic [7:0]          text_byte,
  input  wire logic                restart,
  output logic [2:0]               chars_next,
  output logic [7:0]               candidates_next,
  output stt_pkg::token_kind_e     kind_now,
  output stt_pkg::token_kind_e     kind_next
);

  // work print return true false bool int string
  localparam logic [7:0] WORD_TEXT [8][8] = '{
    '{"w", "o", "r", "k", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00}
  };
  localparam logic [2:0] WORD_LEN [8] = '{3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd4, 3'd3, 3'd6};
  localparam stt_pkg::token_kind_e WORD_KIND [8] = '{
    stt_pkg::TK_KEYWORD, stt_pkg::TK_KEYWORD, stt_pkg::TK_KEYWORD,
    stt_pkg::TK_BOOLEAN, stt_pkg::TK_BOOLEAN,
    stt_pkg::TK_TYPE, stt_pkg::TK_TYPE, stt_pkg::TK_TYPE
  };

  function automatic logic [7:0] advance(logic [2:0] k, logic [7:0] cand, logic [7:0] c);
    logic [7:0] r;
    r = cand;
    for (int i = 0; i < 8; i++) begin
      if (k >= WORD_LEN[i] || WORD_TEXT[i][k] != c) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic stt_pkg::token_kind_e resolve(logic [7:0] cand, logic [2:0] k);
    stt_pkg::token_kind_e r;
    r = stt_pkg::TK_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i] && WORD_LEN[i] == k) begin
        r = WORD_KIND[i];
      end
    end
    return r;
  endfunction

  logic [2:0] k;
  logic [7:0] cand;

  assign k    = restart ? 3'd0 : chars_seen;
  assign cand = restart ? 8'hFF : candidates;

  assign candidates_next = advance(k, cand, text_byte);
  assign chars_next      = (k == 3'd7) ? 3'd7 : k + 3'd1;
  assign kind_now        = resolve(candidates, chars_seen);
  assign kind_next       = resolve(candidates_next, chars_next);

endmodule

`default_nettype wire

// ===== rtl/stt_scan.sv =====
`default_nettype none

module stt_scan #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          text_byte,
  input  wire logic                byte_present,
  input  wire logic                final_item,
  output stt_pkg::token_set_t      toks,
  output logic [1:0]               tok_count
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MINUS,
    MODE_STRING,
    MODE_NUMBER,
    MODE_WORD
  } mode_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  function automatic logic [15:0] to16(logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic logic [POSITION_BITS-1:0] span(logic [POSITION_BITS-1:0] e,
                                                    logic [POSITION_BITS-1:0] s);
    return (e > s) ? e - s : '0;
  endfunction

  function automatic stt_pkg::token_t mk_tok(stt_pkg::token_kind_e k, logic [15:0] s,
                                             logic [15:0] l);
    stt_pkg::token_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  mode_t                     mode, mode_next;
  logic [POSITION_BITS-1:0]  pos, pos_next;
  logic [POSITION_BITS-1:0]  origin, origin_next;
  logic [2:0]                chars, chars_next;
  logic [7:0]                cand, cand_next;

  logic                      word_cont;
  logic [2:0]                wm_chars;
  logic [7:0]                wm_cand;
  stt_pkg::token_kind_e      kind_now, kind_next;

  assign word_cont = (mode == MODE_WORD) && (is_alpha(text_byte) || is_digit(text_byte));

  stt_word_match u_word (
    .chars_seen      (chars),
    .candidates      (cand),
    .text_byte       (text_byte),
    .restart         (!word_cont),
    .chars_next      (wm_chars),
    .candidates_next (wm_cand),
    .kind_now        (kind_now),
    .kind_next       (kind_next)
  );

  always_comb begin
    logic                     taken;
    logic [1:0]               n;
    logic [POSITION_BITS-1:0] str_start;
    mode_next   = mode;
    pos_next    = pos;
    origin_next = origin;
    chars_next  = chars;
    cand_next   = cand;
    toks        = '0;
    n           = 2'd0;
    taken       = 1'b0;
    str_start   = (origin < POS_MAX) ? origin + POSITION_BITS'(1) : POS_MAX;

    if (byte_present) begin
      case (mode)
        MODE_MINUS: begin
          if (text_byte == ">") begin
            toks[n] = mk_tok(stt_pkg::TK_ARROW, to16(origin), 16'd2);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            taken = 1'b1;
          end else begin
            toks[n] = mk_tok(stt_pkg::TK_ERROR, to16(origin), 16'd1);
            n = n + 2'd1;
          end
        end
        MODE_STRING: begin
          if (text_byte == "\"") begin
            toks[n] = mk_tok(stt_pkg::TK_STRING, to16(str_start),
                             to16(span(pos, str_start)));
            n = n + 2'd1;
            mode_next = MODE_IDLE;
          end
          taken = 1'b1;
        end
        MODE_NUMBER: begin
          if (is_digit(text_byte)) begin
            taken = 1'b1;
          end else begin
            toks[n] = mk_tok(stt_pkg::TK_NUMBER, to16(origin), to16(span(pos, origin)));
            n = n + 2'd1;
          end
        end
        MODE_WORD: begin
          if (word_cont) begin
            chars_next = wm_chars;
            cand_next  = wm_cand;
            taken = 1'b1;
          end else begin
            toks[n] = mk_tok(kind_now, to16(origin), to16(span(pos, origin)));
            n = n + 2'd1;
          end
        end
        default: begin
        end
      endcase

      if (!taken) begin
        mode_next = MODE_IDLE;
        if (!is_space(text_byte)) begin
          case (text_byte)
            "(": begin
              toks[n] = mk_tok(stt_pkg::TK_LPAREN, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            ")": begin
              toks[n] = mk_tok(stt_pkg::TK_RPAREN, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            "{": begin
              toks[n] = mk_tok(stt_pkg::TK_LBRACE, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            "}": begin
              toks[n] = mk_tok(stt_pkg::TK_RBRACE, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            ":": begin
              toks[n] = mk_tok(stt_pkg::TK_COLON, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            ",": begin
              toks[n] = mk_tok(stt_pkg::TK_COMMA, to16(pos), 16'd1);
              n = n + 2'd1;
            end
            default: begin
              origin_next = pos;
              if (text_byte == "-") begin
                mode_next = MODE_MINUS;
              end else if (text_byte == "\"") begin
                mode_next = MODE_STRING;
              end else if (is_digit(text_byte)) begin
                mode_next = MODE_NUMBER;
              end else if (is_alpha(text_byte)) begin
                mode_next  = MODE_WORD;
                chars_next = wm_chars;
                cand_next  = wm_cand;
              end else begin
                toks[n] = mk_tok(stt_pkg::TK_ERROR, to16(pos), 16'd1);
                n = n + 2'd1;
              end
            end
          endcase
        end
      end
      pos_next = (pos < POS_MAX) ? pos + POSITION_BITS'(1) : POS_MAX;
    end

    if (final_item) begin
      case (mode_next)
        MODE_MINUS: begin
          toks[n] = mk_tok(stt_pkg::TK_ERROR, to16(origin_next), 16'd1);
          n = n + 2'd1;
        end
        MODE_STRING: begin
          toks[n] = mk_tok(stt_pkg::TK_ERROR, to16(origin_next),
                           to16(span(pos_next, origin_next)));
          n = n + 2'd1;
        end
        MODE_NUMBER: begin
          toks[n] = mk_tok(stt_pkg::TK_NUMBER, to16(origin_next),
                           to16(span(pos_next, origin_next)));
          n = n + 2'd1;
        end
        MODE_WORD: begin
          // a byte in this transaction always advanced the match
          toks[n] = mk_tok(byte_present ? kind_next : kind_now, to16(origin_next),
                           to16(span(pos_next, origin_next)));
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      toks[n] = mk_tok(stt_pkg::TK_END, to16(pos_next), 16'd0);
      n = n + 2'd1;
      mode_next   = MODE_IDLE;
      pos_next    = '0;
      origin_next = '0;
      chars_next  = 3'd0;
      cand_next   = 8'hFF;
    end
    tok_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      origin <= '0;
      chars  <= 3'd0;
      cand   <= 8'hFF;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      origin <= origin_next;
      chars  <= chars_next;
      cand   <= cand_next;
    end
  end

`ifndef ASSERT_OFF
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    accept && final_item |=> pos == '0 && mode == MODE_IDLE)
    else $error("scanner state not cleared after end of input");

  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    accept && final_item |-> tok_count != 2'd0)
    else $error("end of input produced no end token");
`endif

endmodule

`default_nettype wire

// ===== rtl/stt_out_buf.sv =====
`default_nettype none

module stt_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire stt_pkg::token_set_t toks,
  input  wire logic [1:0]          tok_count,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output stt_pkg::token_t          out_tok,
  output logic                     out_last,
  output logic                     busy
);

  stt_pkg::token_set_t slots;
  logic [1:0]          remaining;
  logic [1:0]          rd;
  logic                pop;

  assign out_valid = remaining != 2'd0;
  assign out_last  = remaining == 2'd1;
  assign out_tok   = slots[rd];
  assign pop       = out_valid && !out_stall;
  // room for a new transaction once at most the last result is leaving
  assign busy      = (remaining > 2'd1) || (remaining == 2'd1 && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      rd        <= 2'd0;
    end else if (load) begin
      remaining <= tok_count;
      rd        <= 2'd0;
    end else if (pop) begin
      remaining <= remaining - 2'd1;
      rd        <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= toks;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> remaining == 2'd0 || (remaining == 2'd1 && pop))
    else $error("pending results overwritten");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tok.kind == stt_pkg::TK_END |-> out_last)
    else $error("end token not last of its transaction");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    pop && out_last && !load |=> !out_valid)
    else $error("results shown after last was taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/source_text_tokenizer_top.sv =====
`default_nettype none

// Source text tokenizer. Takes at most one text byte per input transaction and
// returns tokens as kind, start offset and length (token_kind, token_start,
// token_length); last_of_run marks the final token caused by one input
// transaction. A transaction with final_item set flushes any open token and
// closes with an end token, after which offsets restart from zero. An input
// transaction is taken every cycle while each byte yields at most one token and
// the output is not stalled; a byte that yields two or three tokens holds off the
// input while the three-entry result buffer drains a token each unstalled cycle.
// Results appear on the cycle after the byte is taken. Offsets saturate at
// 2^POSITION_BITS - 1 and are reported in their low 16 bits.
module source_text_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        byte_present,
  input  wire logic        final_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_of_run
);

  logic                accept;
  stt_pkg::token_set_t toks;
  logic [1:0]          tok_count;
  stt_pkg::token_t     out_tok;
  logic                busy;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  stt_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .final_item   (final_item),
    .toks         (toks),
    .tok_count    (tok_count)
  );

  stt_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .toks      (toks),
    .tok_count (tok_count),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_tok   (out_tok),
    .out_last  (last_of_run),
    .busy      (busy)
  );

  assign token_kind   = out_tok.kind;
  assign token_start  = out_tok.start;
  assign token_length = out_tok.length;

endmodule

`default_nettype wire
